// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  function automatic int imax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

  localparam int FRAC_BITS = 40;
  localparam int TSC_BITS  = 19;
  localparam int TS_SH     = FRAC_BITS - TSC_BITS;

  localparam longint unsigned PRESS_SCALE = 64'd253952;
  localparam longint unsigned RECIP =
    ((64'd1 << FRAC_BITS) + PRESS_SCALE / 64'd2) / PRESS_SCALE;
  localparam int RECIP_W = $clog2(RECIP + 64'd1);

  localparam int IN_W  = 24;
  localparam int CO_W  = 16;
  localparam int CL_W  = 20;
  localparam int TO_W  = 23;
  localparam int OUT_P_W = 32;

  // pressure datapath widths
  localparam int PS_W   = IN_W + RECIP_W;
  localparam int TS_W   = IN_W + TS_SH;
  localparam int K16P_W = CO_W + PS_W;
  localparam int AV_W   = imax(K16P_W, CO_W + FRAC_BITS) + 1;
  localparam int CR_W   = AV_W;
  localparam int RA_W   = AV_W + PS_W - FRAC_BITS;
  localparam int BV_W   = imax(RA_W, CL_W + FRAC_BITS) + 1;
  localparam int TP_W   = TS_W + PS_W - FRAC_BITS;
  localparam int RB_W   = BV_W + PS_W - FRAC_BITS;
  localparam int RTC_W  = CR_W + TP_W - FRAC_BITS;
  localparam int M01_W  = CO_W + TS_W;
  localparam int S1_W   = imax(imax(RTC_W, M01_W), CL_W + FRAC_BITS) + 2;
  localparam int PV_W   = imax(RB_W, S1_W) + 1;
  localparam int Q_W    = PV_W - FRAC_BITS;

  // wide multiplier geometry
  localparam int MA_W   = imax(imax(BV_W, CR_W), imax(AV_W, TS_W));
  localparam int MB_W   = imax(PS_W, TP_W);
  localparam int MP_W   = MA_W + MB_W;
  localparam int MR_W   = MP_W - FRAC_BITS;
  localparam int NA     = 3;
  localparam int NB     = 2;
  localparam int CA_W   = (MA_W + NA - 1) / NA;
  localparam int CB_W   = (MB_W + NB - 1) / NB;
  localparam int PP_W   = CA_W + CB_W + 2;
  localparam int RW_W   = CA_W + NB * CB_W + 2;
  localparam int WM_LAT = 4;

  // temperature path
  localparam int TM_W     = 12 + IN_W;
  localparam int T_NUM_W  = 44;
  localparam int TEMP_MUL = 100;
  localparam int TOFF_MUL = 50;

  localparam int NSTG = 15;

  localparam logic signed [OUT_P_W-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_P_W-1:0] P_MIN = 32'sh8000_0000;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_TEMP_COEF    = 3'd0;
  localparam logic [2:0] REG_PRESS_OFFSET = 3'd1;
  localparam logic [2:0] REG_PRESS_LIN    = 3'd2;
  localparam logic [2:0] REG_TEMP_CROSS   = 3'd3;
  localparam logic [2:0] REG_CROSS_LIN    = 3'd4;
  localparam logic [2:0] REG_PRESS_SQ     = 3'd5;
  localparam logic [2:0] REG_CROSS_SQ     = 3'd6;
  localparam logic [2:0] REG_PRESS_CUBE   = 3'd7;

  typedef struct packed {
    logic [23:0]     temp_coef_word;
    logic [CL_W-1:0] press_offset;
    logic [CL_W-1:0] press_lin;
    logic [CO_W-1:0] temp_cross;
    logic [CO_W-1:0] cross_lin;
    logic [CO_W-1:0] press_sq;
    logic [CO_W-1:0] cross_sq;
    logic [CO_W-1:0] press_cube;
  } bpc_coef_t;

endpackage

// ===== src/bpc_cfg.sv =====
module bpc_cfg import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output bpc_coef_t         coef
);

  bpc_coef_t  coef_r, coef_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign idx   = cfg_paddr[CFG_AW-1:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      case (idx)
        REG_TEMP_COEF:    coef_nxt.temp_coef_word = cfg_pwdata[23:0];
        REG_PRESS_OFFSET: coef_nxt.press_offset   = cfg_pwdata[CL_W-1:0];
        REG_PRESS_LIN:    coef_nxt.press_lin      = cfg_pwdata[CL_W-1:0];
        REG_TEMP_CROSS:   coef_nxt.temp_cross     = cfg_pwdata[CO_W-1:0];
        REG_CROSS_LIN:    coef_nxt.cross_lin      = cfg_pwdata[CO_W-1:0];
        REG_PRESS_SQ:     coef_nxt.press_sq       = cfg_pwdata[CO_W-1:0];
        REG_CROSS_SQ:     coef_nxt.cross_sq       = cfg_pwdata[CO_W-1:0];
        REG_PRESS_CUBE:   coef_nxt.press_cube     = cfg_pwdata[CO_W-1:0];
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP_COEF:    cfg_prdata = CFG_DW'(coef_r.temp_coef_word);
      REG_PRESS_OFFSET: cfg_prdata = CFG_DW'(coef_r.press_offset);
      REG_PRESS_LIN:    cfg_prdata = CFG_DW'(coef_r.press_lin);
      REG_TEMP_CROSS:   cfg_prdata = CFG_DW'(coef_r.temp_cross);
      REG_CROSS_LIN:    cfg_prdata = CFG_DW'(coef_r.cross_lin);
      REG_PRESS_SQ:     cfg_prdata = CFG_DW'(coef_r.press_sq);
      REG_CROSS_SQ:     cfg_prdata = CFG_DW'(coef_r.cross_sq);
      REG_PRESS_CUBE:   cfg_prdata = CFG_DW'(coef_r.press_cube);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign coef       = coef_r;

endmodule

// ===== src/bpc_wmul.sv =====
// fixed-point product, truncated toward zero; four stages
module bpc_wmul import bpc_pkg::*; (
  input  logic                    clk,
  input  logic [WM_LAT-1:0]       en,
  input  logic signed [MA_W-1:0]  a,
  input  logic signed [MB_W-1:0]  b,
  output logic signed [MR_W-1:0]  p
);

  logic [NA*CA_W-1:0]       a_x;
  logic [NB*CB_W-1:0]       b_x;
  logic signed [CA_W:0]     a_c [NA];
  logic signed [CB_W:0]     b_c [NB];
  logic signed [PP_W-1:0]   pp_r [NA][NB];
  logic signed [RW_W-1:0]   row_nxt [NA];
  logic signed [RW_W-1:0]   row_r [NA];
  logic signed [MP_W-1:0]   sum_nxt, sum_r;
  logic signed [MR_W-1:0]   p_nxt, p_r;
  logic                     corr;

  assign a_x = (NA*CA_W)'(a);
  assign b_x = (NB*CB_W)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        a_c[i] = signed'({a_x[NA*CA_W-1], a_x[i*CA_W +: CA_W]});
      end else begin
        a_c[i] = signed'({1'b0, a_x[i*CA_W +: CA_W]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        b_c[j] = signed'({b_x[NB*CB_W-1], b_x[j*CB_W +: CB_W]});
      end else begin
        b_c[j] = signed'({1'b0, b_x[j*CB_W +: CB_W]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = RW_W'(pp_r[i][0]);
      for (int j = 1; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW_W'(pp_r[i][j]) <<< (j * CB_W));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (MP_W'(row_r[i]) <<< (i * CA_W));
    end
  end

  assign corr  = sum_r[MP_W-1] & (|sum_r[FRAC_BITS-1:0]);
  assign p_nxt = MR_W'(sum_r >>> FRAC_BITS) + MR_W'(corr);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= PP_W'(a_c[i]) * PP_W'(b_c[j]);
        end
      end
    end
    if (en[1]) begin
      for (int i = 0; i < NA; i++) begin
        row_r[i] <= row_nxt[i];
      end
    end
    if (en[2]) begin
      sum_r <= sum_nxt;
    end
    if (en[3]) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== src/bpc_pctl.sv =====
module bpc_pctl import bpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output logic [NSTG-1:0] en
);

  logic [NSTG-1:0] v_r, v_nxt;

  // a stage may load when any stage from it onwards is empty or the item leaves
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_ready | ~(&(v_r | ((NSTG'(1) << k) - NSTG'(1))));
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

endmodule

// ===== src/baro_pressure_temp_compensation_top.sv =====
// Pipeline: 15 register stages; a stalled output lets empty stages keep filling.
// Throughput: one item per cycle while in_ready is high; the four wide fixed-point
// multipliers are each four stages deep and fully pipelined.
// Reset: synchronous, active low; clears the stage valid bits and sets all
// coefficient registers to zero.
module baro_pressure_temp_compensation_top import bpc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IN_W-1:0]     in_raw_temperature,
  input  logic signed [IN_W-1:0]     in_raw_pressure,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [TO_W-1:0]     out_temperature_centideg,
  output logic signed [OUT_P_W-1:0]  out_pressure_pa,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_AW-1:0]          cfg_paddr,
  input  logic [CFG_DW-1:0]          cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  bpc_coef_t       coef;
  logic [NSTG-1:0] en;

  logic signed [11:0]     toff, tslope;
  logic signed [CL_W-1:0] k00, k10;
  logic signed [CO_W-1:0] k01, k11, k20, k21, k30;

  logic signed [PS_W-1:0]    ps_r [0:7];
  logic signed [PS_W-1:0]    ps_nxt;
  logic signed [TS_W-1:0]    ts_r, ts_nxt;
  logic signed [TM_W-1:0]    tmul_r, tmul_nxt;
  logic signed [K16P_W-1:0]  m30_r, m21_r, m30_nxt, m21_nxt;
  logic signed [M01_W-1:0]   m01_r [1:8];
  logic signed [M01_W-1:0]   m01_nxt;
  logic signed [T_NUM_W-1:0] tnum_r, tnum_nxt;
  logic signed [AV_W-1:0]    a_r, a_nxt;
  logic signed [CR_W-1:0]    cr_r [2:4];
  logic signed [CR_W-1:0]    cr_nxt;
  logic signed [TO_W-1:0]    tq_r [2:NSTG-1];
  logic signed [TO_W-1:0]    tq_nxt;
  logic                      tcorr;
  logic signed [BV_W-1:0]    b_r, b_nxt;
  logic signed [S1_W-1:0]    s1_r [9:11];
  logic signed [S1_W-1:0]    s1_nxt;
  logic signed [PV_W-1:0]    poly_r, poly_nxt;
  logic signed [Q_W-1:0]     q_r, q_nxt;
  logic                      pcorr;
  logic signed [OUT_P_W-1:0] press_r, press_nxt;
  logic signed [MR_W-1:0]    tp, ra, rtc, rb;

  localparam logic signed [PS_W-1:0] RECIP_S = PS_W'(RECIP);

  bpc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coef        (coef)
  );

  bpc_pctl u_pctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  assign toff   = coef.temp_coef_word[23:12];
  assign tslope = coef.temp_coef_word[11:0];
  assign k00    = coef.press_offset;
  assign k10    = coef.press_lin;
  assign k01    = coef.temp_cross;
  assign k11    = coef.cross_lin;
  assign k20    = coef.press_sq;
  assign k21    = coef.cross_sq;
  assign k30    = coef.press_cube;

  // stage 0: scaled inputs
  assign ps_nxt   = PS_W'(in_raw_pressure) * RECIP_S;
  assign ts_nxt   = TS_W'(in_raw_temperature) <<< TS_SH;
  assign tmul_nxt = TM_W'(tslope) * TM_W'(in_raw_temperature);

  // stage 1: coefficient products
  assign m30_nxt  = K16P_W'(k30) * K16P_W'(ps_r[0]);
  assign m21_nxt  = K16P_W'(k21) * K16P_W'(ps_r[0]);
  assign m01_nxt  = M01_W'(k01) * M01_W'(ts_r);
  assign tnum_nxt = T_NUM_W'(tmul_r) * T_NUM_W'(TEMP_MUL)
                  + ((T_NUM_W'(toff) * T_NUM_W'(TOFF_MUL)) <<< TSC_BITS);

  // stage 2
  assign a_nxt  = AV_W'(m30_r) + (AV_W'(k20) <<< FRAC_BITS);
  assign cr_nxt = CR_W'(m21_r) + (CR_W'(k11) <<< FRAC_BITS);
  assign tcorr  = tnum_r[T_NUM_W-1] & (|tnum_r[TSC_BITS-1:0]);
  assign tq_nxt = TO_W'(tnum_r >>> TSC_BITS) + TO_W'(tcorr);

  // stage 7, 9, 12, 13, 14
  assign b_nxt    = BV_W'(ra) + (BV_W'(k10) <<< FRAC_BITS);
  assign s1_nxt   = S1_W'(rtc) + S1_W'(m01_r[8]) + (S1_W'(k00) <<< FRAC_BITS);
  assign poly_nxt = PV_W'(rb) + PV_W'(s1_r[11]);
  assign pcorr    = poly_r[PV_W-1] & (|poly_r[FRAC_BITS-1:0]);
  assign q_nxt    = Q_W'(poly_r >>> FRAC_BITS) + Q_W'(pcorr);

  always_comb begin
    if ((&q_r[Q_W-1:OUT_P_W-1]) | ~(|q_r[Q_W-1:OUT_P_W-1])) begin
      press_nxt = OUT_P_W'(q_r);
    end else if (q_r[Q_W-1]) begin
      press_nxt = P_MIN;
    end else begin
      press_nxt = P_MAX;
    end
  end

  // tp = ts*ps, stages 1..4
  bpc_wmul u_mul_tp (
    .clk (clk),
    .en  (en[4:1]),
    .a   (MA_W'(ts_r)),
    .b   (MB_W'(ps_r[0])),
    .p   (tp)
  );

  // a*ps, stages 3..6
  bpc_wmul u_mul_a (
    .clk (clk),
    .en  (en[6:3]),
    .a   (MA_W'(a_r)),
    .b   (MB_W'(ps_r[2])),
    .p   (ra)
  );

  // tp*cr, stages 5..8
  bpc_wmul u_mul_tc (
    .clk (clk),
    .en  (en[8:5]),
    .a   (MA_W'(cr_r[4])),
    .b   (MB_W'(tp)),
    .p   (rtc)
  );

  // b*ps, stages 8..11
  bpc_wmul u_mul_b (
    .clk (clk),
    .en  (en[11:8]),
    .a   (MA_W'(b_r)),
    .b   (MB_W'(ps_r[7])),
    .p   (rb)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ps_r[0] <= ps_nxt;
      ts_r    <= ts_nxt;
      tmul_r  <= tmul_nxt;
    end
    for (int k = 1; k <= 7; k++) begin
      if (en[k]) begin
        ps_r[k] <= ps_r[k-1];
      end
    end
    if (en[1]) begin
      m30_r    <= m30_nxt;
      m21_r    <= m21_nxt;
      m01_r[1] <= m01_nxt;
      tnum_r   <= tnum_nxt;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        m01_r[k] <= m01_r[k-1];
      end
    end
    if (en[2]) begin
      a_r      <= a_nxt;
      cr_r[2]  <= cr_nxt;
      tq_r[2]  <= tq_nxt;
    end
    for (int k = 3; k <= 4; k++) begin
      if (en[k]) begin
        cr_r[k] <= cr_r[k-1];
      end
    end
    for (int k = 3; k <= NSTG - 1; k++) begin
      if (en[k]) begin
        tq_r[k] <= tq_r[k-1];
      end
    end
    if (en[7]) begin
      b_r <= b_nxt;
    end
    if (en[9]) begin
      s1_r[9] <= s1_nxt;
    end
    for (int k = 10; k <= 11; k++) begin
      if (en[k]) begin
        s1_r[k] <= s1_r[k-1];
      end
    end
    if (en[12]) begin
      poly_r <= poly_nxt;
    end
    if (en[13]) begin
      q_r <= q_nxt;
    end
    if (en[NSTG-1]) begin
      press_r <= press_nxt;
    end
  end

  assign out_temperature_centideg = tq_r[NSTG-1];
  assign out_pressure_pa          = press_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked while the pipeline has room");

  a_drain_admits: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while the output drains");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite
     && cfg_paddr[CFG_AW-1:2] == REG_PRESS_OFFSET)
    |=> (cfg_paddr != $past(cfg_paddr))
        || (cfg_prdata == CFG_DW'($past(cfg_pwdata[CL_W-1:0]))))
    else $error("offset coefficient read-back mismatch");
`endif

endmodule
